// ===== hw/rtl/sph_pkg.sv =====
// sph_pkg: shared types, constants and the cordic arctangent table
// for the sphere patch point evaluator; depends on nothing
package sph_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SINCOS_LAT   = CORDIC_STEPS + 2;
  localparam int PIPE_LEN     = CORDIC_STEPS + 7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0]        HALF_PI     = 31'd1686629713;

  localparam logic [2:0] REG_RADIUS     = 3'd0;
  localparam logic [2:0] REG_PHI_LOW    = 3'd1;
  localparam logic [2:0] REG_PHI_HIGH   = 3'd2;
  localparam logic [2:0] REG_THETA_SPAN = 3'd3;
  localparam logic [2:0] REG_ROW_X      = 3'd4;
  localparam logic [2:0] REG_ROW_Y      = 3'd5;
  localparam logic [2:0] REG_ROW_Z      = 3'd6;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [33:0] cwide_t;

  function automatic cwide_t atan_entry(input int i);
    cwide_t r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      default: r = 34'sd32768;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sph_sincos.sv =====
// sph_sincos: pipelined cordic cosine and sine of a 32 bit binary angle, q30
// one cordic step per stage; depends on sph_pkg
module sph_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic [31:0]       ang,
  output sph_pkg::q30_t     cos_out,
  output sph_pkg::q30_t     sin_out
);
  import sph_pkg::*;

  localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  cwide_t     x [0:CORDIC_STEPS];
  cwide_t     y [0:CORDIC_STEPS];
  cwide_t     z [0:CORDIC_STEPS];
  logic [1:0] q [0:CORDIC_STEPS];

  logic [31:0] a;
  logic [60:0] zprod;
  logic [60:0] zround;

  always_comb begin
    a      = ang & AMASK;
    zprod  = {31'd0, a[29:0]} * {30'd0, HALF_PI};
    zround = zprod + 61'(32'd1 << 29);
  end

  always_ff @(posedge clk) begin
    x[0] <= CORDIC_GAIN;
    y[0] <= '0;
    z[0] <= cwide_t'({3'd0, zround[60:30]});
    q[0] <= a[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      q[i+1] <= q[i];
      if (!z[i][33]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_entry(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_entry(i);
      end
    end
  end

  cwide_t cq, sq;
  q30_t   cc, sc;

  function automatic q30_t clamp30(input cwide_t v);
    q30_t r;
    if (v > 34'sd1073741824)       r = 32'sd1073741824;
    else if (v < -34'sd1073741824) r = -32'sd1073741824;
    else                           r = q30_t'(v);
    return r;
  endfunction

  always_comb begin
    case (q[CORDIC_STEPS])
      2'd0: begin cq = x[CORDIC_STEPS];  sq = y[CORDIC_STEPS];  end
      2'd1: begin cq = -y[CORDIC_STEPS]; sq = x[CORDIC_STEPS];  end
      2'd2: begin cq = -x[CORDIC_STEPS]; sq = -y[CORDIC_STEPS]; end
      default: begin cq = y[CORDIC_STEPS]; sq = -x[CORDIC_STEPS]; end
    endcase
    cc = clamp30(cq);
    sc = clamp30(sq);
  end

  always_ff @(posedge clk) begin
    cos_out <= cc;
    sin_out <= sc;
  end

endmodule

// ===== hw/rtl/sphere_patch_point_eval_top.sv =====
// sphere_patch_point_eval_top: vertex of a tessellated partial sphere
// depends on sph_pkg and sph_sincos
//
// One point is taken in every clock cycle: busy stays low, and each word
// appears on the result ports for one cycle with done high. Each point passes
// the angle registers, two 16-step cordic pipelines running side by side, then
// the normal, point, product and output registers. The
// receiver cannot stall the block, so results must be taken as they come.
// Write the configuration registers only while no point is in flight.
module sphere_patch_point_eval_top #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        param_u,
  input  logic [15:0]        param_v,
  output logic               done,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        tex_s,
  output logic [15:0]        tex_t,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data
);
  import sph_pkg::*;

  logic [23:0] radius;
  logic [15:0] phi_low, phi_high;
  logic [16:0] theta_span;
  logic [63:0] row_x, row_y, row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 24'd65536;
      phi_low    <= 16'hC000;
      phi_high   <= 16'h4000;
      theta_span <= 17'd65536;
      row_x      <= 64'd256;
      row_y      <= 64'd1 << 24;
      row_z      <= 64'd1 << 40;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIUS:     radius     <= wr_data[23:0];
        REG_PHI_LOW:    phi_low    <= wr_data[15:0];
        REG_PHI_HIGH:   phi_high   <= wr_data[15:0];
        REG_THETA_SPAN: theta_span <= wr_data[16:0];
        REG_ROW_X:      row_x      <= wr_data;
        REG_ROW_Y:      row_y      <= wr_data;
        REG_ROW_Z:      row_z      <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid and texture words travel alongside the data
  logic        vpipe [0:PIPE_LEN-1];
  logic [15:0] upipe [0:PIPE_LEN-1];
  logic [15:0] wpipe [0:PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LEN; i++) vpipe[i] <= 1'b0;
    end else begin
      vpipe[0] <= start;
      for (int i = 1; i < PIPE_LEN; i++) vpipe[i] <= vpipe[i-1];
    end
  end

  always_ff @(posedge clk) begin
    upipe[0] <= param_u;
    wpipe[0] <= param_v;
    for (int i = 1; i < PIPE_LEN; i++) begin
      upipe[i] <= upipe[i-1];
      wpipe[i] <= wpipe[i-1];
    end
  end

  // angles
  logic signed [16:0] phi_diff;
  logic signed [33:0] phi_prod;
  logic [32:0]        theta_prod;
  logic [31:0]        phi32, theta32;

  always_comb begin
    phi_diff   = 17'($signed(phi_high)) - 17'($signed(phi_low));
    phi_prod   = 34'($signed({1'b0, param_v})) * 34'(phi_diff);
    theta_prod = {17'd0, param_u} * {16'd0, theta_span};
  end

  always_ff @(posedge clk) begin
    phi32   <= {phi_low, 16'd0} + phi_prod[31:0];
    theta32 <= theta_prod[31:0];
  end

  q30_t ct, st, cp, sp;

  sph_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_theta (
    .clk(clk), .ang(theta32), .cos_out(ct), .sin_out(st)
  );

  sph_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_phi (
    .clk(clk), .ang(phi32), .cos_out(cp), .sin_out(sp)
  );

  // unit normal, q30
  logic signed [63:0] nxp, nyp;
  q30_t nx, ny, nz;

  always_comb begin
    nxp = 64'(ct) * 64'(cp) + 64'sd536870912;
    nyp = 64'(st) * 64'(cp) + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    nx <= q30_t'(nxp >>> 30);
    ny <= q30_t'(nyp >>> 30);
    nz <= sp;
  end

  // object point q16.16 and output normal
  function automatic logic signed [26:0] scale_r(input logic [23:0] r, input q30_t n);
    logic signed [56:0] p;
    p = 57'($signed({1'b0, r})) * 57'(n) + 57'sd536870912;
    return 27'(p >>> 30);
  endfunction

  function automatic logic signed [15:0] norm_q15(input q30_t n);
    logic signed [32:0] t;
    logic signed [17:0] s;
    t = 33'(n) + 33'sd16384;
    s = 18'(t >>> 15);
    if (s > 18'sd32767)       return 16'sh7FFF;
    else if (s < -18'sd32768) return 16'sh8000;
    else                      return 16'(s);
  endfunction

  logic signed [26:0] px, py, pz;
  logic signed [15:0] nox [0:1];
  logic signed [15:0] noy [0:1];
  logic signed [15:0] noz [0:1];

  always_ff @(posedge clk) begin
    px     <= scale_r(radius, nx);
    py     <= scale_r(radius, ny);
    pz     <= scale_r(radius, nz);
    nox[0] <= norm_q15(nx);
    noy[0] <= norm_q15(ny);
    noz[0] <= norm_q15(nz);
    for (int i = 1; i < 2; i++) begin
      nox[i] <= nox[i-1];
      noy[i] <= noy[i-1];
      noz[i] <= noz[i-1];
    end
  end

  // transform products
  logic signed [42:0] mp [0:2][0:2];
  logic signed [15:0] m3 [0:2];
  logic [63:0]        rows [0:2];

  always_comb begin
    rows[0] = row_x;
    rows[1] = row_y;
    rows[2] = row_z;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      mp[r][0] <= 43'($signed(rows[r][15:0])) * 43'(px);
      mp[r][1] <= 43'($signed(rows[r][31:16])) * 43'(py);
      mp[r][2] <= 43'($signed(rows[r][47:32])) * 43'(pz);
      m3[r]    <= $signed(rows[r][63:48]);
    end
  end

  function automatic logic signed [31:0] row_sum(input logic signed [42:0] a,
                                                 input logic signed [42:0] b,
                                                 input logic signed [42:0] c,
                                                 input logic signed [15:0] d);
    logic signed [45:0] acc;
    logic signed [37:0] s;
    acc = 46'(a) + 46'(b) + 46'(c) + (46'(d) <<< 24) + 46'sd128;
    s   = 38'(acc >>> 8);
    if (s > 38'sd2147483647)       return 32'sh7FFFFFFF;
    else if (s < -38'sd2147483648) return 32'sh80000000;
    else                           return 32'(s);
  endfunction

  always_ff @(posedge clk) begin
    pos_x  <= row_sum(mp[0][0], mp[0][1], mp[0][2], m3[0]);
    pos_y  <= row_sum(mp[1][0], mp[1][1], mp[1][2], m3[1]);
    pos_z  <= row_sum(mp[2][0], mp[2][1], mp[2][2], m3[2]);
    norm_x <= nox[1];
    norm_y <= noy[1];
    norm_z <= noz[1];
  end

  assign done  = vpipe[PIPE_LEN-1];
  assign tex_s = upipe[PIPE_LEN-1];
  assign tex_t = wpipe[PIPE_LEN-1];

endmodule

// ===== hw/rtl/sph_checker.sv =====
// sph_checker: port-level assertions for the sphere patch point evaluator
// depends on sph_pkg; bound to sphere_patch_point_eval_top
module sph_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] param_u,
  input logic [15:0] param_v,
  input logic [15:0] tex_s,
  input logic [15:0] tex_t
);
  import sph_pkg::*;

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(PIPE_LEN) done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_LEN))
    else $error("result without accepted word");

  a_tex_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (tex_s == $past(param_u, PIPE_LEN)) && (tex_t == $past(param_v, PIPE_LEN)))
    else $error("texture word out of order");

endmodule

bind sphere_patch_point_eval_top sph_checker u_sph_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .param_u(param_u), .param_v(param_v), .tex_s(tex_s), .tex_t(tex_t)
);

// ===== verif/sphere_patch_point_eval_top_tb.sv =====
// sphere_patch_point_eval_top_tb: self-checking bench for the sphere patch point evaluator
// holds its own fixed-point cordic predictor and checks every word against it
// depends on sph_pkg and sphere_patch_point_eval_top
module sphere_patch_point_eval_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sph_pkg::*;

  localparam int ANGLE_W   = 16;
  localparam int STEPS     = 16;
  localparam int LIMIT     = 400000;
  localparam int N_RANDOM  = 1500;
  localparam longint GAIN  = 652032874;
  localparam longint HPI   = 1686629713;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        s, t;
  } vertex_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] param_u = '0, param_v = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [63:0] wr_data = '0;
  logic busy, done;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [15:0] tex_s, tex_t;

  logic [23:0]        sph_radius;
  logic signed [15:0] lat_lo, lat_hi;
  logic [16:0]        lon_span;
  logic [63:0]        row_x, row_y, row_z;

  vertex_t vertex_q[$];
  int errors = 0, cycles = 0, n_words = 0, n_sent = 0, n_cfg = 0;

  longint atan_tab[STEPS] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768};

  sphere_patch_point_eval_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic angle_sincos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, dx, dy;
    a = (ang >> (32 - ANGLE_W)) << (32 - ANGLE_W);
    z = (longint'(a[29:0]) * HPI + (64'sd1 << 29)) >>> 30;
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clamp(c, -(64'sd1 << 30), 64'sd1 << 30);
    s = clamp(s, -(64'sd1 << 30), 64'sd1 << 30);
  endtask

  function automatic logic [31:0] apply_row(logic [63:0] row, longint px, longint py,
                                            longint pz);
    longint acc;
    acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
        + longint'($signed(row[47:32])) * pz + longint'($signed(row[63:48])) * (64'sd1 << 24);
    return 32'(clamp((acc + 128) >>> 8, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic logic [15:0] to_q15(longint n);
    return 16'(clamp((n + (64'sd1 << 14)) >>> 15, -32768, 32767));
  endfunction

  task automatic eval_vertex(input logic [15:0] u, input logic [15:0] v, output vertex_t e);
    longint lo, phi, ct, st, cp, sp, nx, ny, nz, px, py, pz, r;
    lo = longint'(lat_lo);
    phi = lo * 65536 + longint'(v) * (longint'(lat_hi) - lo);
    angle_sincos(32'(longint'(u) * longint'(lon_span)), ct, st);
    angle_sincos(32'(phi), cp, sp);
    r = longint'(sph_radius);
    nx = (ct * cp + (64'sd1 << 29)) >>> 30;
    ny = (st * cp + (64'sd1 << 29)) >>> 30;
    nz = sp;
    px = (r * nx + (64'sd1 << 29)) >>> 30;
    py = (r * ny + (64'sd1 << 29)) >>> 30;
    pz = (r * nz + (64'sd1 << 29)) >>> 30;
    e.px = apply_row(row_x, px, py, pz);
    e.py = apply_row(row_y, px, py, pz);
    e.pz = apply_row(row_z, px, py, pz);
    e.nx = to_q15(nx);
    e.ny = to_q15(ny);
    e.nz = to_q15(nz);
    e.s = u;
    e.t = v;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // acceptance, result check and run limit
  always @(posedge clk) begin
    vertex_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && start && !busy) begin
      eval_vertex(param_u, param_v, e);
      vertex_q.insert(vertex_q.size(), e);
      n_sent++;
    end
    if (!rst && done) begin
      n_words++;
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual pos %h %h %h", $realtime,
                 pos_x, pos_y, pos_z);
      end else begin
        e = vertex_q.pop_front();
        check_field("pos_x", e.px, pos_x);
        check_field("pos_y", e.py, pos_y);
        check_field("pos_z", e.pz, pos_z);
        check_field("norm_x", {16'd0, e.nx}, {16'd0, norm_x});
        check_field("norm_y", {16'd0, e.ny}, {16'd0, norm_y});
        check_field("norm_z", {16'd0, e.nz}, {16'd0, norm_z});
        check_field("tex_s", {16'd0, e.s}, {16'd0, tex_s});
        check_field("tex_t", {16'd0, e.t}, {16'd0, tex_t});
      end
    end
  end

  task automatic send_point(input logic [15:0] u, input logic [15:0] v);
    start <= 1'b1;
    param_u <= u;
    param_v <= v;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      REG_RADIUS:     sph_radius = data[23:0];
      REG_PHI_LOW:    lat_lo = data[15:0];
      REG_PHI_HIGH:   lat_hi = data[15:0];
      REG_THETA_SPAN: lon_span = data[16:0];
      REG_ROW_X:      row_x = data;
      REG_ROW_Y:      row_y = data;
      REG_ROW_Z:      row_z = data;
      default: ;
    endcase
    n_cfg++;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] pick_row();
    logic [63:0] r;
    if ($urandom_range(0, 1)) return {$urandom, $urandom};
    for (int k = 0; k < 4; k++) r[16*k +: 16] = 16'($urandom_range(0, 1024) - 512);
    return r;
  endfunction

  task automatic random_setup();
    write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ? 64'hFFFFFF
                                                    : 64'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_PHI_LOW, 64'($urandom_range(0, 1) ? $urandom
                                                    : $urandom_range(0, 32768) - 16384));
    write_reg(REG_PHI_HIGH, 64'($urandom_range(0, 1) ? $urandom
                                                     : $urandom_range(0, 32768) - 16384));
    write_reg(REG_THETA_SPAN, 64'($urandom_range(0, 1) ? $urandom_range(0, 17'h1FFFF)
                                                       : $urandom_range(0, 65536)));
    write_reg(REG_ROW_X, pick_row());
    write_reg(REG_ROW_Y, pick_row());
    write_reg(REG_ROW_Z, pick_row());
    write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  task automatic test_corner_points();
    logic [15:0] pts[6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};
    drain();
    for (int i = 0; i < 6; i++) send_point(pts[i], pts[5 - i]);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'h0000, 16'h0000);
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(REG_RADIUS, 64'hFFFFFF);
    write_reg(REG_PHI_LOW, 64'h4000);
    write_reg(REG_PHI_HIGH, 64'hC000);
    write_reg(REG_THETA_SPAN, 64'h1FFFF);
    write_reg(REG_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_ROW_Y, 64'h8000_8000_8000_8000);
    write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNUSED, 64'h0);
    send_point(16'h0000, 16'h8000);
    send_point(16'h5555, 16'hAAAA);
    send_point(16'hFFFF, 16'h0000);
    drain();
    write_reg(REG_RADIUS, 64'h0);
    write_reg(REG_PHI_LOW, 64'h8000);
    write_reg(REG_PHI_HIGH, 64'h7FFF);
    write_reg(REG_THETA_SPAN, 64'h0);
    write_reg(REG_ROW_X, 64'h0);
    write_reg(REG_ROW_Y, 64'h8000_0000_0000_0000);
    write_reg(REG_ROW_Z, 64'h7FFF_0000_0000_0000);
    send_point(16'h1234, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_RADIUS, 64'h10000);
    write_reg(REG_PHI_LOW, 64'h0);
    write_reg(REG_PHI_HIGH, 64'h0);
    write_reg(REG_THETA_SPAN, 64'h10000);
    send_point(16'h0000, 16'h0000);
    send_point(16'h4000, 16'h0000);
  endtask

  task automatic test_random_points();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) begin
        drain();
        random_setup();
      end
      if (n == 700) drain();
      send_point($urandom, $urandom);
      if (n < N_RANDOM - 200 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    sph_radius = 24'd65536;
    lat_lo = -16'sd16384;
    lat_hi = 16'sd16384;
    lon_span = 17'd65536;
    row_x = 64'd256;
    row_y = 64'd1 << 24;
    row_z = 64'd1 << 40;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_points();
    test_config_extremes();
    test_random_points();
    drain();
    repeat (PIPE_LEN + 10) @(posedge clk);
    $display("covered %0d points and %0d register writes, %0d words checked",
             n_sent, n_cfg, n_words);
    $display("configs included extreme radius, inverted and wrapped latitude, saturation");
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
